// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies; the asserting module must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Implication form of the above.
`define ASSERT_IMP(label, ante, cons) \
    `ASSERT_CLK(label, (ante) |-> (cons))

`endif

// ===== sv/bgcd_pkg.sv =====
// Types and constants for the binary gcd block.
// No dependencies; used by binary_gcd_ctz.
package bgcd_pkg;

    // Width of the operand and result ports.
    localparam int DATA_W = 64;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_COMMON = 6'b000010,
        S_STRIPA = 6'b000100,
        S_STRIPB = 6'b001000,
        S_SUB    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

endpackage

// ===== sv/binary_gcd_ctz.sv =====
// A request with a zero operand goes straight to the result strobe; otherwise the sequencer
// removes the shared trailing zeros, strips the remaining zeros from each operand, then
// subtracts the smaller from the larger and strips the difference until the operands match.
// A new request is taken in the cycle the result shows. One WIDTH-bit compare/subtract unit.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops the strobe.
// Top level of the binary gcd block; depends on bgcd_pkg.
module binary_gcd_ctz
    import bgcd_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_first_operand,
    input  logic [DATA_W-1:0] i_second_operand,
    output logic              o_busy,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_divisor
);

    localparam int CW = $clog2(WIDTH);

    t_state              r_state, n_state;
    logic [WIDTH-1:0]    r_a, n_a;
    logic [WIDTH-1:0]    r_b, n_b;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_valid, n_valid;
    logic [DATA_W-1:0]   r_divisor, n_divisor;

    logic [WIDTH-1:0]    w_in_a, w_in_b;
    logic                w_lt;
    logic [WIDTH-1:0]    w_minuend, w_subtrahend, w_diff;
    logic [WIDTH-1:0]    w_shl;

    // Operands masked to the datapath width
    assign w_in_a = i_first_operand[WIDTH-1:0];
    assign w_in_b = i_second_operand[WIDTH-1:0];

    // Shared compare and subtract: larger minus smaller
    assign w_lt         = r_a < r_b;
    assign w_minuend    = w_lt ? r_b : r_a;
    assign w_subtrahend = w_lt ? r_a : r_b;
    assign w_diff       = w_minuend - w_subtrahend;

    // Put the shared power of two back
    assign w_shl = r_a << r_cnt;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_divisor = r_divisor;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_a   = w_in_a;
                    n_b   = w_in_b;
                    n_cnt = '0;
                    if (w_in_a == '0 || w_in_b == '0) begin
                        n_a     = w_in_a | w_in_b;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_COMMON;
                    end
                end
            end
            S_COMMON: begin
                // both even: drop one shared factor of two
                if (!r_a[0] && !r_b[0]) begin
                    n_a   = r_a >> 1;
                    n_b   = r_b >> 1;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_state = S_STRIPA;
                end
            end
            S_STRIPA: begin
                if (!r_a[0]) n_a = r_a >> 1;
                else         n_state = S_STRIPB;
            end
            S_STRIPB: begin
                if (!r_b[0]) n_b = r_b >> 1;
                else         n_state = S_SUB;
            end
            S_SUB: begin
                if (w_lt) begin
                    n_b     = w_diff;
                    n_state = S_STRIPB;
                end else if (r_a == r_b) begin
                    n_state = S_DONE;
                end else begin
                    n_a     = r_b;
                    n_b     = w_diff;
                    n_state = S_STRIPB;
                end
            end
            S_DONE: begin
                n_valid   = 1'b1;
                n_divisor = DATA_W'(w_shl);
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_cnt     <= n_cnt;
        r_divisor <= n_divisor;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_divisor = r_divisor;

endmodule

// ===== sv/bgcd_checker.sv =====
// Port-level checks for binary_gcd_ctz, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bgcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic [63:0] i_first_operand,
    input logic [63:0] i_second_operand,
    input logic        o_busy,
    input logic        o_valid,
    input logic [63:0] o_divisor
);

    // An accepted request makes the block busy
    `ASSERT_CLK(a_req_busy, (i_start && !o_busy) |=> o_busy)
    // Result strobe shows only once the block is free again
    `ASSERT_IMP(a_valid_idle, o_valid, !o_busy)
    // Strobe lasts one cycle
    `ASSERT_CLK(a_valid_pulse, o_valid |=> !o_valid)
    // Leaving busy always delivers a result
    `ASSERT_IMP(a_done_valid, $fell(o_busy), o_valid)

endmodule

bind binary_gcd_ctz bgcd_checker u_bgcd_checker (.*);
